[rtl/core/fp16_to_fp6_pack4_macros.svh]
// ----------------------------------------------------------------------------
// fp16_to_fp6_pack4 assertion macros
// Concurrent assertion shorthands used by the FP16 to FP6 packer.
// ----------------------------------------------------------------------------
`ifndef FP16_TO_FP6_PACK4_MACROS_SVH
`define FP16_TO_FP6_PACK4_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define FP6P_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define FP6P_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/fp6p_pkg.sv]
// ----------------------------------------------------------------------------
// fp6p_pkg
// Request and result types and lane conversion helpers for the FP6 packer.
// ----------------------------------------------------------------------------
`default_nettype none

package fp6p_pkg;

	localparam logic [14:0] MAG_MIN = 15'h2C00;	// 0.0625
	localparam logic [14:0] MAG_MAX = 15'h4F00;	// 28.0
	localparam logic [4:0]  EXP_NORM_MIN = 5'd13;
	localparam logic [4:0]  EXP_BIAS_DIFF = 5'd12;
	localparam logic [4:0]  EXP_SUB_HALF = 5'd12;
	localparam logic [4:0]  EXP_SUB_QUARTER = 5'd11;

	typedef struct packed {
		logic [15:0] lane0_half;
		logic [15:0] lane1_half;
		logic [15:0] lane2_half;
		logic [15:0] lane3_half;
	} fp6p_req_t;

	typedef struct packed {
		logic [7:0] packed_byte0;
		logic [7:0] packed_byte1;
		logic [7:0] packed_byte2;
		logic       out_of_range;
		logic [3:0] bad_lanes;
	} fp6p_res_t;

	// E3M2, bias 3, truncating; small exponents shift into the subnormal range
	function automatic logic [5:0] lane_code(input logic [15:0] h);
		logic [4:0] e;
		logic [1:0] m;
		logic [2:0] ne;
		logic [1:0] nm;
		e  = h[14:10];
		m  = h[9:8];
		ne = '0;
		nm = '0;
		if (e >= EXP_NORM_MIN) begin
			ne = 3'(e - EXP_BIAS_DIFF);
			nm = m;
		end else if (e == EXP_SUB_HALF) begin
			nm = {1'b1, m[1]};
		end else if (e == EXP_SUB_QUARTER) begin
			nm = 2'b01;
		end
		return {h[15], ne, nm};
	endfunction

	function automatic logic lane_bad(input logic [15:0] h);
		logic [14:0] mag;
		mag = h[14:0];
		return ((mag != '0) && (mag < MAG_MIN)) || (mag > MAG_MAX);
	endfunction

endpackage

`default_nettype wire

[rtl/core/fp6p_req_if.sv]
// ----------------------------------------------------------------------------
// fp6p_req_if
// Valid/ready channel carrying four FP16 lanes.
// ----------------------------------------------------------------------------
`default_nettype none

interface fp6p_req_if;
	import fp6p_pkg::*;

	logic      valid;
	logic      ready;
	fp6p_req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/core/fp6p_res_if.sv]
// ----------------------------------------------------------------------------
// fp6p_res_if
// Valid/ready channel carrying one packed FP6 group and its range flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface fp6p_res_if;
	import fp6p_pkg::*;

	logic      valid;
	logic      ready;
	fp6p_res_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/core/fp16_to_fp6_pack4.sv]
// Throughput: one request per cycle while the result output is not stalled.
// Path: input register, conversion logic, result register.
// A stalled result holds in the result register; the input register takes a
// request while empty, or once the result register is free in the same cycle.
// Reset (arst_n low) empties both stages at once; no payload is cleared.
// ----------------------------------------------------------------------------
// fp16_to_fp6_pack4
// Converts four FP16 lanes to E3M2 FP6 and packs them into three bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module fp16_to_fp6_pack4 (
	input wire logic clk,
	input wire logic arst_n,
	fp6p_req_if.sink feed,
	fp6p_res_if.source result
);
	import fp6p_pkg::*;

	logic      valid_s1;
	fp6p_req_t req_s1;
	logic      valid_s2;
	fp6p_res_t res_s2;

	logic      load_s2;
	logic      load_s1;
	logic [5:0] code [4];
	logic [3:0] bad;
	fp6p_res_t res_next;

	assign load_s2 = valid_s1 && (!valid_s2 || result.ready);
	assign feed.ready = !valid_s1 || load_s2;
	assign load_s1 = feed.valid && feed.ready;

	always_comb begin
		code[0] = lane_code(req_s1.lane0_half);
		code[1] = lane_code(req_s1.lane1_half);
		code[2] = lane_code(req_s1.lane2_half);
		code[3] = lane_code(req_s1.lane3_half);
		bad = {lane_bad(req_s1.lane3_half), lane_bad(req_s1.lane2_half),
			lane_bad(req_s1.lane1_half), lane_bad(req_s1.lane0_half)};
		res_next.out_of_range = |bad;
		res_next.bad_lanes = bad;
		// drop the whole group when any lane is flagged
		if (|bad) begin
			res_next.packed_byte0 = '0;
			res_next.packed_byte1 = '0;
			res_next.packed_byte2 = '0;
		end else begin
			res_next.packed_byte0 = {code[0], code[1][5:4]};
			res_next.packed_byte1 = {code[1][3:0], code[2][5:2]};
			res_next.packed_byte2 = {code[2][1:0], code[3]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (feed.ready) begin
				valid_s1 <= feed.valid;
			end
			if (!valid_s2 || result.ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			req_s1 <= feed.payload;
		end
		if (load_s2) begin
			res_s2 <= res_next;
		end
	end

	assign result.valid = valid_s2;
	assign result.payload = res_s2;

`include "fp16_to_fp6_pack4_macros.svh"

	`FP6P_ASSERT_IMP(a_flag_zeroes, clk, arst_n, valid_s2 && res_s2.out_of_range,
		(res_s2.packed_byte0 == '0) && (res_s2.packed_byte1 == '0) && (res_s2.packed_byte2 == '0),
		"flagged group carries nonzero bytes")
	`FP6P_ASSERT_IMP(a_flag_summary, clk, arst_n, valid_s2,
		res_s2.out_of_range == (res_s2.bad_lanes != '0),
		"out_of_range disagrees with bad_lanes")
	`FP6P_ASSERT_NXT(a_advance_fills, clk, arst_n, load_s2,
		valid_s2,
		"advanced request missing from result stage")
	`FP6P_ASSERT_NXT(a_accept_fills, clk, arst_n, load_s1,
		valid_s1,
		"accepted request missing from input stage")

endmodule

`default_nettype wire
